[hdl/aevr_pkg.sv]
// shared types, constants and tables of the attitude euler and vector rotation core
`default_nettype none
package aevr_pkg;

	// field widths
	localparam int QUAT_W    = 16;
	localparam int VEC_W     = 16;
	localparam int ANGLE_W   = 16;
	localparam int MODE_W    = 3;
	localparam int QFRAC     = 14;
	localparam int S_DATA_W  = 128;
	localparam int M_DATA_W  = 96;

	// datapath widths
	localparam int MUL_A_W   = 36;
	localparam int MUL_B_W   = 29;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int CORDIC_W  = 48;
	localparam int CORDIC_N  = 30;

	// request modes
	localparam logic [MODE_W-1:0] MODE_QUAT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CAL   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OFF   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLR   = 3'd4;

	// quaternion component selects
	localparam logic [1:0] QX = 2'd0;
	localparam logic [1:0] QY = 2'd1;
	localparam logic [1:0] QZ = 2'd2;
	localparam logic [1:0] QW = 2'd3;

	// product-sum jobs
	localparam logic [3:0] JOB_ROLL_Y = 4'd0;
	localparam logic [3:0] JOB_ROLL_X = 4'd1;
	localparam logic [3:0] JOB_PITCH  = 4'd2;
	localparam logic [3:0] JOB_YAW_Y  = 4'd3;
	localparam logic [3:0] JOB_YAW_X  = 4'd4;
	localparam logic [3:0] JOB_ROT0   = 4'd5;
	localparam logic [3:0] JOB_ROT8   = 4'd13;

	typedef struct packed {
		logic [1:0] a0;
		logic [1:0] b0;
		logic       neg0;
		logic [1:0] a1;
		logic [1:0] b1;
		logic       neg1;
		logic       one_minus;
	} job_info_t;

	// each job is a0*b0 +/- a1*b1, then doubled or taken as one minus twice
	function automatic job_info_t aevr_job(input logic [3:0] idx);
		job_info_t j;
		unique case (idx)
			4'd0:    j = '{QW, QX, 1'b0, QY, QZ, 1'b0, 1'b0};
			4'd1:    j = '{QX, QX, 1'b0, QY, QY, 1'b0, 1'b1};
			4'd2:    j = '{QW, QY, 1'b0, QZ, QX, 1'b1, 1'b0};
			4'd3:    j = '{QW, QZ, 1'b0, QX, QY, 1'b0, 1'b0};
			4'd4:    j = '{QY, QY, 1'b0, QZ, QZ, 1'b0, 1'b1};
			4'd5:    j = '{QY, QY, 1'b0, QZ, QZ, 1'b0, 1'b1};
			4'd6:    j = '{QX, QY, 1'b0, QW, QZ, 1'b1, 1'b0};
			4'd7:    j = '{QX, QZ, 1'b0, QW, QY, 1'b0, 1'b0};
			4'd8:    j = '{QX, QY, 1'b0, QW, QZ, 1'b0, 1'b0};
			4'd9:    j = '{QX, QX, 1'b0, QZ, QZ, 1'b0, 1'b1};
			4'd10:   j = '{QY, QZ, 1'b0, QW, QX, 1'b1, 1'b0};
			4'd11:   j = '{QX, QZ, 1'b0, QW, QY, 1'b1, 1'b0};
			4'd12:   j = '{QY, QZ, 1'b0, QW, QX, 1'b0, 1'b0};
			4'd13:   j = '{QX, QX, 1'b0, QY, QY, 1'b0, 1'b1};
			default: j = '0;
		endcase
		return j;
	endfunction

	// arctangent of 2^-i in 32-bit turns
	function automatic logic [31:0] aevr_atan(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[hdl/aevr_mul.sv]
// shared signed multiplier with registered product
`default_nettype none
module aevr_mul (
	input  wire logic                                clk,
	input  wire logic signed [aevr_pkg::MUL_A_W-1:0] a,
	input  wire logic signed [aevr_pkg::MUL_B_W-1:0] b,
	output logic signed [aevr_pkg::PROD_W-1:0]       p
);
	import aevr_pkg::*;

	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
`default_nettype wire

[hdl/attitude_euler_and_vector_rotation_core.sv]
// top level: quaternion attitude to euler angles and vector rotation
//
//  channel  dir  signals                   content
//  s_axis   in   tvalid tready tdata tuser one request: mode in tuser, operands in tdata
//  m_axis   out  tvalid tready tdata tuser one result per request: angles, vector, valid flag
//
// one shared multiplier and one shared shift/add unit run under a sequencer.
// mode 0 takes 5 product jobs, two or three cordic runs of 30 rotations after
// normalization, and a bitwise square root when pitch is not clamped.
// mode 1 with a quaternion held takes 9 product jobs; other modes go straight to the output.
// reset clears the attitude to identity; stalls on m_axis hold the result and the
// block takes no request until the result is taken.
`default_nettype none
module attitude_euler_and_vector_rotation_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, offset_angle
	input  wire logic [aevr_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// mode
	input  wire logic [aevr_pkg::MODE_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// roll, pitch, yaw, out_x, out_y, out_z
	output logic [aevr_pkg::M_DATA_W-1:0]          m_axis_tdata,
	// valid_res
	output logic [0:0]                             m_axis_tuser
);
	import aevr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TERM_MUL, ST_TERM_ACC, ST_JOB_END, ST_SQR_MUL, ST_SQR_END,
		ST_ISQRT, ST_NORM, ST_CORDIC, ST_ANG_END, ST_DOT_MUL, ST_DOT_ACC, ST_OUT
	} state_t;

	localparam logic signed [MUL_A_W-1:0]  ONE_Q     = MUL_A_W'(1) <<< (2 * QFRAC);
	localparam logic signed [CORDIC_W-1:0] NORM_LIM  = CORDIC_W'(1) <<< 40;
	localparam logic [56:0]                SQRT_TOP  = 57'(1) << (4 * QFRAC);
	localparam logic [31:0]                HALF_TURN = 32'h80000000;
	localparam logic [15:0]                PITCH_UP  = 16'h4000;
	localparam logic [15:0]                PITCH_DN  = 16'hC000;
	localparam logic signed [51:0]         RND_HALF  = 52'(1) <<< (2 * QFRAC - 1);

	state_t                       state_q;
	logic signed [QUAT_W-1:0]     quat_q [4];
	logic signed [VEC_W-1:0]      vec_q  [3];
	logic signed [VEC_W-1:0]      res_q  [3];
	logic                         quat_valid_q;
	logic                         offset_set_q;
	logic [ANGLE_W-1:0]           offset_q;
	logic [ANGLE_W-1:0]           roll_q;
	logic [ANGLE_W-1:0]           pitch_q;
	logic [ANGLE_W-1:0]           yaw_q;

	logic [3:0]                   job_q;
	logic                         term_q;
	logic signed [32:0]           acc_q;
	logic signed [MUL_A_W-1:0]    cy_q;
	logic signed [MUL_A_W-1:0]    r_q;
	logic                         sp_neg_q;
	logic [27:0]                  mag_q;
	logic [56:0]                  n_q;
	logic [57:0]                  root_q;
	logic [56:0]                  bit_q;
	logic signed [CORDIC_W-1:0]   x_q;
	logic signed [CORDIC_W-1:0]   y_q;
	logic [31:0]                  ang_q;
	logic [4:0]                   iter_q;
	logic [1:0]                   col_q;
	logic [1:0]                   row_q;
	logic signed [51:0]           dot_q;

	// shared multiplier
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]     prod;

	job_info_t                    ji;
	logic [1:0]                   sel_a;
	logic [1:0]                   sel_b;
	logic signed [32:0]           term_v;
	logic signed [MUL_A_W-1:0]    acc_x2;
	logic signed [MUL_A_W-1:0]    job_val;
	logic [MUL_A_W-1:0]           sp_abs;
	logic signed [CORDIC_W-1:0]   ax;
	logic signed [CORDIC_W-1:0]   ay;
	logic signed [CORDIC_W-1:0]   dx;
	logic signed [CORDIC_W-1:0]   dy;
	logic [31:0]                  ang_rnd;
	logic [ANGLE_W-1:0]           ang16;
	logic [57:0]                  sq_try;
	logic signed [51:0]           dot_sum;
	logic signed [51:0]           dot_rnd;
	logic signed [VEC_W-1:0]      dot_sat;
	logic [ANGLE_W-1:0]           new_off;
	logic                         accept;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {res_q[2], res_q[1], res_q[0], yaw_q, pitch_q, roll_q};
	assign m_axis_tuser  = quat_valid_q;

	// product-sum job decode
	always_comb begin
		ji     = aevr_job(job_q);
		sel_a  = term_q ? ji.a1 : ji.a0;
		sel_b  = term_q ? ji.b1 : ji.b0;
		acc_x2 = MUL_A_W'(acc_q) <<< 1;
		job_val = ji.one_minus ? (ONE_Q - acc_x2) : acc_x2;
		sp_abs  = job_val[MUL_A_W-1] ? MUL_A_W'(-job_val) : MUL_A_W'(job_val);
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_SQR_MUL: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(mag_q);
			end
			ST_DOT_MUL: begin
				mul_a = r_q;
				mul_b = MUL_B_W'(vec_q[col_q]);
			end
			default: begin
				mul_a = MUL_A_W'(quat_q[sel_a]);
				mul_b = MUL_B_W'(quat_q[sel_b]);
			end
		endcase
	end

	aevr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// shift/add unit: cordic step, square root step, rounding
	always_comb begin
		term_v  = term_q == ji.neg1 ? 33'(prod) : 33'(prod);
		if ((term_q ? ji.neg1 : ji.neg0))
			term_v = -33'(prod);
		ax      = x_q[CORDIC_W-1] ? -x_q : x_q;
		ay      = y_q[CORDIC_W-1] ? -y_q : y_q;
		dx      = y_q >>> iter_q;
		dy      = x_q >>> iter_q;
		ang_rnd = ang_q + 32'h00008000;
		ang16   = ang_rnd[31:16];
		sq_try  = root_q + 58'(bit_q);
		dot_sum = dot_q + 52'(prod);
		dot_rnd = (dot_sum + RND_HALF) >>> (2 * QFRAC);
		if (dot_rnd > 52'sd32767)
			dot_sat = 16'sh7FFF;
		else if (dot_rnd < -52'sd32768)
			dot_sat = -16'sh8000;
		else
			dot_sat = dot_rnd[VEC_W-1:0];
		new_off = offset_set_q ? offset_q : (16'd0 - ang16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			quat_q[0]    <= '0;
			quat_q[1]    <= '0;
			quat_q[2]    <= '0;
			quat_q[3]    <= 16'sd16384;
			quat_valid_q <= 1'b0;
			offset_set_q <= 1'b0;
			offset_q     <= '0;
			roll_q       <= '0;
			pitch_q      <= '0;
			yaw_q        <= '0;
			res_q[0]     <= '0;
			res_q[1]     <= '0;
			res_q[2]     <= '0;
			job_q        <= '0;
			term_q       <= 1'b0;
			iter_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// no attitude yet: vector passes through, else results start at zero
						for (int k = 0; k < 3; k++)
							res_q[k] <= (s_axis_tuser == MODE_ROT && !quat_valid_q) ?
								s_axis_tdata[64+16*k +: 16] : '0;
						state_q <= (s_axis_tuser == MODE_QUAT ||
							(s_axis_tuser == MODE_ROT && quat_valid_q)) ? ST_TERM_MUL : ST_OUT;
						unique case (s_axis_tuser)
							MODE_QUAT: begin
								for (int k = 0; k < 4; k++)
									quat_q[k] <= s_axis_tdata[16*k +: 16];
								quat_valid_q <= 1'b1;
								job_q        <= JOB_ROLL_Y;
								term_q       <= 1'b0;
							end
							MODE_ROT: begin
								if (quat_valid_q) begin
									for (int k = 0; k < 3; k++)
										vec_q[k] <= s_axis_tdata[64+16*k +: 16];
									job_q   <= JOB_ROT0;
									term_q  <= 1'b0;
									col_q   <= '0;
									row_q   <= '0;
									dot_q   <= '0;
								end
							end
							MODE_CAL: begin
								if (quat_valid_q) begin
									offset_q     <= offset_q - yaw_q;
									offset_set_q <= 1'b1;
								end
							end
							MODE_OFF: begin
								offset_q     <= s_axis_tdata[112 +: 16];
								offset_set_q <= 1'b1;
							end
							MODE_CLR: begin
								quat_q[0]    <= '0;
								quat_q[1]    <= '0;
								quat_q[2]    <= '0;
								quat_q[3]    <= 16'sd16384;
								quat_valid_q <= 1'b0;
								offset_set_q <= 1'b0;
								offset_q     <= '0;
								roll_q       <= '0;
								pitch_q      <= '0;
								yaw_q        <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TERM_MUL: begin
					state_q <= ST_TERM_ACC;
				end
				ST_TERM_ACC: begin
					acc_q <= term_q ? acc_q + term_v : term_v;
					if (term_q) begin
						state_q <= ST_JOB_END;
					end else begin
						term_q  <= 1'b1;
						state_q <= ST_TERM_MUL;
					end
				end
				ST_JOB_END: begin
					term_q <= 1'b0;
					unique case (job_q)
						JOB_ROLL_Y, JOB_YAW_Y: begin
							cy_q    <= job_val;
							job_q   <= job_q + 4'd1;
							state_q <= ST_TERM_MUL;
						end
						JOB_ROLL_X, JOB_YAW_X: begin
							x_q     <= CORDIC_W'(job_val);
							y_q     <= CORDIC_W'(cy_q);
							state_q <= ST_NORM;
						end
						JOB_PITCH: begin
							// sine at or beyond one clamps to a quarter turn
							if (job_val >= ONE_Q) begin
								pitch_q <= PITCH_UP;
								job_q   <= JOB_YAW_Y;
								state_q <= ST_TERM_MUL;
							end else if (job_val <= -ONE_Q) begin
								pitch_q <= PITCH_DN;
								job_q   <= JOB_YAW_Y;
								state_q <= ST_TERM_MUL;
							end else begin
								sp_neg_q <= job_val[MUL_A_W-1];
								mag_q    <= sp_abs[27:0];
								state_q  <= ST_SQR_MUL;
							end
						end
						default: begin
							r_q     <= job_val;
							state_q <= ST_DOT_MUL;
						end
					endcase
				end
				ST_SQR_MUL: begin
					state_q <= ST_SQR_END;
				end
				ST_SQR_END: begin
					// cosine = sqrt(1 - s*s), bit by bit
					n_q     <= SQRT_TOP - 57'(prod);
					root_q  <= '0;
					bit_q   <= SQRT_TOP;
					state_q <= ST_ISQRT;
				end
				ST_ISQRT: begin
					if (bit_q == '0) begin
						x_q     <= CORDIC_W'(root_q);
						y_q     <= sp_neg_q ? -CORDIC_W'(mag_q) : CORDIC_W'(mag_q);
						state_q <= ST_NORM;
					end else begin
						if (58'(n_q) >= sq_try) begin
							n_q    <= 57'(58'(n_q) - sq_try);
							root_q <= (root_q >> 1) + 58'(bit_q);
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				ST_NORM: begin
					if (x_q == '0 && y_q == '0) begin
						ang_q   <= '0;
						state_q <= ST_ANG_END;
					end else if (ax < NORM_LIM && ay < NORM_LIM) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						// left half plane: start from a half turn
						if (x_q[CORDIC_W-1]) begin
							x_q   <= -x_q;
							y_q   <= -y_q;
							ang_q <= HALF_TURN;
						end else begin
							ang_q <= '0;
						end
						iter_q  <= '0;
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (!y_q[CORDIC_W-1] && y_q != '0) begin
						x_q   <= x_q + dx;
						y_q   <= y_q - dy;
						ang_q <= ang_q + aevr_atan(iter_q);
					end else begin
						x_q   <= x_q - dx;
						y_q   <= y_q + dy;
						ang_q <= ang_q - aevr_atan(iter_q);
					end
					if (iter_q == 5'(CORDIC_N - 1))
						state_q <= ST_ANG_END;
					else
						iter_q <= iter_q + 5'd1;
				end
				ST_ANG_END: begin
					unique case (job_q)
						JOB_ROLL_X: begin
							roll_q  <= ang16;
							job_q   <= JOB_PITCH;
							state_q <= ST_TERM_MUL;
						end
						JOB_PITCH: begin
							pitch_q <= ang16;
							job_q   <= JOB_YAW_Y;
							state_q <= ST_TERM_MUL;
						end
						default: begin
							// first heading after clear becomes zero
							offset_q     <= new_off;
							offset_set_q <= 1'b1;
							yaw_q        <= ang16 + new_off;
							state_q      <= ST_OUT;
						end
					endcase
				end
				ST_DOT_MUL: begin
					state_q <= ST_DOT_ACC;
				end
				ST_DOT_ACC: begin
					if (col_q == 2'd2) begin
						res_q[row_q] <= dot_sat;
						dot_q        <= '0;
						col_q        <= '0;
						row_q        <= row_q + 2'd1;
					end else begin
						dot_q <= dot_sum;
						col_q <= col_q + 2'd1;
					end
					if (job_q == JOB_ROT8) begin
						state_q <= ST_OUT;
					end else begin
						job_q   <= job_q + 4'd1;
						state_q <= ST_TERM_MUL;
					end
				end
				ST_OUT: begin
					if (m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the attitude euler and vector rotation core
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import aevr_pkg::*;

	localparam int N_RANDOM = 1680;
	localparam int LIMIT    = 3000000;
	localparam int DRAIN    = 400;

	// modes with no function, the core only reports its state
	localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	// one request as it travels on s_axis
	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [15:0]       qx, qy, qz, qw;
		logic [15:0]       vx, vy, vz;
		logic [15:0]       ofs;
	} attitude_req_t;

	// one result as it travels on m_axis
	typedef struct {
		logic [15:0] roll, pitch, yaw;
		logic [15:0] gx, gy, gz;
		logic        held;
	} attitude_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [MODE_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	attitude_req_t pending_reqs[$];
	attitude_res_t expected_results[$];
	attitude_req_t cur_req;
	int n_sent = 0;
	int n_taken = 0;
	int n_mismatch = 0;
	int cycles = 0;

	// predictor state
	longint   att_q[4];
	bit       att_held;
	bit       ofs_known;
	bit [15:0] hdg_ofs;
	bit [15:0] st_roll, st_pitch, st_yaw;

	// arctangent of 2^-i, 2^32 to a turn
	bit [31:0] atan_steps[30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

	attitude_euler_and_vector_rotation_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic bit [31:0] vector_angle(longint y, longint x);
		bit [31:0] ang;
		longint ax, ay, m, dx, dy;
		ang = '0;
		if (x == 0 && y == 0) return '0;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		m = ax > ay ? ax : ay;
		while (m < (64'sd1 <<< 40)) begin
			x = x * 2; y = y * 2; m = m * 2;
		end
		// left half plane: flip by half a turn
		if (x < 0) begin
			ang = 32'h80000000; x = -x; y = -y;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; ang += atan_steps[i];
			end else begin
				x -= dx; y += dy; ang -= atan_steps[i];
			end
		end
		return ang;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// 32-bit turn rounded half up to 16 bits
	function automatic bit [15:0] round_angle(bit [31:0] a);
		bit [63:0] t;
		t = {32'b0, a} + 64'h8000;
		return t[31:16];
	endfunction

	function automatic bit [15:0] sat16(longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic void refresh_angles();
		longint ex, ey, ez, es, one, sp, mag;
		bit [31:0] pa;
		bit [15:0] raw;
		ex = att_q[0]; ey = att_q[1]; ez = att_q[2]; es = att_q[3];
		one = 64'sd1 <<< 28;
		st_roll = round_angle(vector_angle(2 * (es * ex + ey * ez),
			one - 2 * (ex * ex + ey * ey)));
		sp = 2 * (es * ey - ez * ex);
		// pitch pinned at a quarter turn once the sine reaches one
		if (sp >= one) pa = 32'h40000000;
		else if (sp <= -one) pa = 32'hC0000000;
		else begin
			mag = sp < 0 ? -sp : sp;
			pa = vector_angle(sp < 0 ? -mag : mag,
				longint'(int_sqrt((64'd1 << 56) - 64'(mag * mag))));
		end
		st_pitch = round_angle(pa);
		raw = round_angle(vector_angle(2 * (es * ez + ex * ey),
			one - 2 * (ey * ey + ez * ez)));
		// first update zeroes the heading
		if (!ofs_known) begin
			hdg_ofs = -raw;
			ofs_known = 1'b1;
		end
		st_yaw = raw + hdg_ofs;
	endfunction

	function automatic void clear_attitude();
		att_q[0] = 0; att_q[1] = 0; att_q[2] = 0; att_q[3] = 16384;
		att_held = 1'b0; ofs_known = 1'b0; hdg_ofs = '0;
		st_roll = '0; st_pitch = '0; st_yaw = '0;
	endfunction

	function automatic attitude_res_t predict_attitude(attitude_req_t r);
		attitude_res_t o;
		longint ex, ey, ez, es, one, s;
		longint m[9], v[3];
		ex = att_q[0]; ey = att_q[1]; ez = att_q[2]; es = att_q[3];
		one = 64'sd1 <<< 28;
		o.gx = '0; o.gy = '0; o.gz = '0;
		case (r.mode)
			MODE_QUAT: begin
				att_q[0] = longint'($signed(r.qx));
				att_q[1] = longint'($signed(r.qy));
				att_q[2] = longint'($signed(r.qz));
				att_q[3] = longint'($signed(r.qw));
				att_held = 1'b1;
				refresh_angles();
			end
			MODE_ROT: begin
				v[0] = longint'($signed(r.vx));
				v[1] = longint'($signed(r.vy));
				v[2] = longint'($signed(r.vz));
				if (!att_held) begin
					// no attitude yet: vector goes straight through
					o.gx = r.vx; o.gy = r.vy; o.gz = r.vz;
				end else begin
					m[0] = one - 2 * (ey * ey + ez * ez);
					m[1] = 2 * (ex * ey - es * ez);
					m[2] = 2 * (ex * ez + es * ey);
					m[3] = 2 * (ex * ey + es * ez);
					m[4] = one - 2 * (ex * ex + ez * ez);
					m[5] = 2 * (ey * ez - es * ex);
					m[6] = 2 * (ex * ez - es * ey);
					m[7] = 2 * (ey * ez + es * ex);
					m[8] = one - 2 * (ex * ex + ey * ey);
					s = m[0] * v[0] + m[1] * v[1] + m[2] * v[2];
					o.gx = sat16((s + (64'sd1 <<< 27)) >>> 28);
					s = m[3] * v[0] + m[4] * v[1] + m[5] * v[2];
					o.gy = sat16((s + (64'sd1 <<< 27)) >>> 28);
					s = m[6] * v[0] + m[7] * v[1] + m[8] * v[2];
					o.gz = sat16((s + (64'sd1 <<< 27)) >>> 28);
				end
			end
			MODE_CAL: begin
				if (att_held) begin
					hdg_ofs = hdg_ofs - st_yaw;
					ofs_known = 1'b1;
				end
			end
			MODE_OFF: begin
				hdg_ofs = r.ofs;
				ofs_known = 1'b1;
			end
			MODE_CLR: clear_attitude();
			default: ;
		endcase
		o.roll = st_roll; o.pitch = st_pitch; o.yaw = st_yaw;
		o.held = att_held;
		return o;
	endfunction

	function automatic attitude_req_t make_req(logic [2:0] mode, int qx, int qy, int qz,
			int qw, int vx, int vy, int vz, int ofs);
		attitude_req_t r;
		r.mode = mode;
		r.qx = qx[15:0]; r.qy = qy[15:0]; r.qz = qz[15:0]; r.qw = qw[15:0];
		r.vx = vx[15:0]; r.vy = vy[15:0]; r.vz = vz[15:0]; r.ofs = ofs[15:0];
		return r;
	endfunction

	// well-formed request: unit quaternion, full-range vector and offset
	function automatic attitude_req_t unit_req(logic [2:0] mode);
		attitude_req_t r;
		real c[4], n;
		for (int i = 0; i < 4; i++) c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
		n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
		if (n == 0.0) begin
			c[3] = 1.0; n = 1.0;
		end
		r = make_req(mode, $rtoi(c[0] / n * 16384.0), $rtoi(c[1] / n * 16384.0),
			$rtoi(c[2] / n * 16384.0), $rtoi(c[3] / n * 16384.0),
			$urandom, $urandom, $urandom, $urandom);
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_attitude(cur_req));
				n_sent <= n_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				// busy window around the middle of the run: no gaps
				if (pending_reqs.size() > 0 &&
						((n_sent > 700 && n_sent < 1000) || $urandom_range(0, 99) >= 35)) begin
					cur_req = pending_reqs.pop_front();
					s_axis_tdata <= {cur_req.ofs, cur_req.vz, cur_req.vy, cur_req.vx,
						cur_req.qw, cur_req.qz, cur_req.qy, cur_req.qx};
					s_axis_tuser <= cur_req.mode;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		attitude_res_t exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (n_taken > 700 && n_taken < 1000) || $urandom_range(0, 99) >= 35;
			if (m_axis_tvalid && m_axis_tready) begin
				n_taken <= n_taken + 1;
				if (expected_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10) $display("unexpected result %h", m_axis_tdata);
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tdata[15:0] !== exp_r.roll ||
							m_axis_tdata[31:16] !== exp_r.pitch ||
							m_axis_tdata[47:32] !== exp_r.yaw ||
							m_axis_tdata[63:48] !== exp_r.gx ||
							m_axis_tdata[79:64] !== exp_r.gy ||
							m_axis_tdata[95:80] !== exp_r.gz ||
							m_axis_tuser[0] !== exp_r.held) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch result %0d: exp r%h p%h y%h x%h y%h z%h v%b",
								n_taken, exp_r.roll, exp_r.pitch, exp_r.yaw, exp_r.gx,
								exp_r.gy, exp_r.gz, exp_r.held, " got %h v%b",
								m_axis_tdata, m_axis_tuser);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [2:0] md;
		int pick;
		clear_attitude();
		// directed: no attitude held yet
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, -32768, 32767, 0, 0));
		pending_reqs.push_back(make_req(MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_QUAT, 0, 0, 0, 16384, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, 32767, -32768, -1, 0));
		// zero quaternion: every arctangent sees a zero y operand and x at one
		pending_reqs.push_back(make_req(MODE_QUAT, 0, 0, 0, 0, 0, 0, 0, 0));
		// x only: roll at half a turn
		pending_reqs.push_back(make_req(MODE_QUAT, 16384, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, 32767, 32767, -32768, 0));
		// pitch sine beyond one, both signs
		pending_reqs.push_back(make_req(MODE_QUAT, 0, 11586, 0, 11586, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_QUAT, 0, -11586, 0, 11586, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_QUAT, 0, 16384, 0, 16384, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_OFF, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		pending_reqs.push_back(make_req(MODE_QUAT, -16384, 16384, -16384, 16384, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_OFF, 0, 0, 0, 0, 0, 0, 0, 0));
		// components far outside the unit range: saturation on rotation
		pending_reqs.push_back(make_req(MODE_QUAT, -32768, 32767, -32768, 32767, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, -32768, -32768, -32768, 0));
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, 32767, 32767, 32767, 0));
		pending_reqs.push_back(make_req(MODE_SPARE5, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_SPARE6, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_SPARE7, -1, -1, -1, -1, -1, -1, -1, -1));
		pending_reqs.push_back(make_req(MODE_CLR, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(MODE_ROT, 0, 0, 0, 0, 123, -456, 789, 0));
		// random: mostly unit quaternions and sensible sequences, some raw noise
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 36) md = MODE_QUAT;
			else if (pick < 70) md = MODE_ROT;
			else if (pick < 78) md = MODE_CAL;
			else if (pick < 85) md = MODE_OFF;
			else if (pick < 89) md = MODE_CLR;
			else md = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 80)
				pending_reqs.push_back(unit_req(md));
			else
				pending_reqs.push_back(make_req(md, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
		if (n_mismatch == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
